@@ rtl/gsr_pkg.sv @@
package gsr_pkg;

   // Per-cycle shift command broadcast to every cell of the chain.
   typedef struct packed {
      logic shift_right;  // cell i takes cell i-1 (push / alignment / forward drain)
      logic shift_left;   // cell i takes cell i+1 (reverse drain)
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_REV   = 4'b0010,
      ST_ALIGN = 4'b0100,
      ST_FWD   = 4'b1000
   } state_type;

endpackage

@@ rtl/gsr_cell.sv @@
module gsr_cell
   import gsr_pkg::*;
#(
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] data
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_right) begin
         data_in = left_data;
      end else if (ctrl.shift_left) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ rtl/gsr_chain.sv @@
module gsr_chain
   import gsr_pkg::*;
#(
   parameter int MAX_GROUP  = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] in_data,
   output logic [DATA_WIDTH-1:0] head_data,
   output logic [DATA_WIDTH-1:0] tail_data
);

   logic [DATA_WIDTH-1:0] cell_q [MAX_GROUP];

   for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;

      if (i == 0) begin : g_first
         assign left_d = in_data;
      end else begin : g_mid_l
         assign left_d = cell_q[i-1];
      end

      if (i == MAX_GROUP - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_q[i+1];
      end

      gsr_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_q[i])
      );
   end

   assign head_data = cell_q[0];
   assign tail_data = cell_q[MAX_GROUP-1];

endmodule

@@ rtl/stream_group_reverser_top.sv @@
// Stream group reverser.
// Input beats (req_*) carry one value each; req_tlast marks the end of a list.
// Values gather in a chain of MAX_GROUP cells. When group_size values have
// gathered, the group leaves on rsp_* newest first as one burst; rsp_tlast
// marks the final beat of every burst. If a list ends before a group fills,
// the partial group leaves in arrival order. group_size 0 acts as 1,
// values above MAX_GROUP act as MAX_GROUP. csr_wr_en writes group_size.
// Timing: a completed group of n values drains one beat per cycle while the
// receiver is ready. A partial group first shifts to the chain's tail, then
// drains n beats. Input is held off (req_tready low) while a group aligns or
// drains, set by the single shifting chain.
// Reset: fill count cleared, group_size = 1, no burst pending. Cell contents
// are not reset. A receiver stall during a burst freezes the chain and holds the beat.
module stream_group_reverser_top
   import gsr_pkg::*;
#(
   parameter int MAX_GROUP  = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // config
   input  logic                               csr_wr_en,
   input  logic [6:0]                         csr_wr_data,   // group_size
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]    req_tdata,     // [DATA_WIDTH-1:0] item_value
   input  logic                               req_tlast,     // end_of_list
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [((DATA_WIDTH+7)/8)*8-1:0]    rsp_tdata,     // [DATA_WIDTH-1:0] out_value
   output logic                               rsp_tlast      // last_of_burst
);

   localparam int TW = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int CW = $clog2(MAX_GROUP + 1);     // counts 0..MAX_GROUP
   localparam int KW = (CW > 7) ? CW : 7;         // compare width
   localparam logic [KW-1:0] MAX_K = KW'(MAX_GROUP);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_GROUP);

   logic [6:0]    gsize_ff, gsize_in;
   state_type     state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [KW-1:0] k_eff;
   logic [CW-1:0] n_new;
   logic          req_fire, rsp_fire;
   cell_ctrl_type ctrl;
   logic [DATA_WIDTH-1:0] head_data, tail_data;

   // effective group size, clamped to 1..MAX_GROUP
   always_comb begin
      k_eff = KW'(gsize_ff);
      if (gsize_ff == 7'd0) begin
         k_eff = KW'(1);
      end else if (KW'(gsize_ff) > MAX_K) begin
         k_eff = MAX_K;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = (state_ff == ST_REV) || (state_ff == ST_FWD);
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign n_new      = fill_ff + CW'(1);

   // chain shifts right on push, on alignment and forward drain;
   // left while a group pops out newest first
   always_comb begin
      ctrl.shift_right = req_fire || (state_ff == ST_ALIGN)
                         || ((state_ff == ST_FWD) && rsp_tready);
      ctrl.shift_left  = (state_ff == ST_REV) && rsp_tready;
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      cnt_in   = cnt_ff;
      gsize_in = csr_wr_en ? csr_wr_data : gsize_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (KW'(n_new) >= k_eff) begin
                  state_in = ST_REV;
                  cnt_in   = n_new;
                  fill_in  = '0;
               end else if (req_tlast) begin
                  // partial group: slide it to the tail first
                  state_in = ST_ALIGN;
                  cnt_in   = MAX_C - n_new;
                  fill_in  = n_new;
               end else begin
                  fill_in  = n_new;
               end
            end
         end
         ST_ALIGN: begin
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_FWD;
               cnt_in   = fill_ff;
               fill_in  = '0;
            end
         end
         ST_REV, ST_FWD: begin
            if (rsp_fire) begin
               cnt_in = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         cnt_ff   <= '0;
         gsize_ff <= 7'd1;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         gsize_ff <= gsize_in;
      end
   end

   gsr_chain #(
      .MAX_GROUP  (MAX_GROUP),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .in_data   (req_tdata[DATA_WIDTH-1:0]),
      .head_data (head_data),
      .tail_data (tail_data)
   );

   // newest at the head for reversed bursts, oldest at the tail otherwise
   assign rsp_tdata = TW'((state_ff == ST_REV) ? head_data : tail_data);
   assign rsp_tlast = (cnt_ff == CW'(1));

endmodule
